// ===== hdl/vocm_pkg.sv =====
// shared types, constants, microprogram layout and cube vertex table for the voxel mesher
package vocm_pkg;

    localparam int CHUNK_EDGE_DEF = 16;
    localparam int CRD_W          = 4;
    localparam int BLK_W          = 8;
    localparam int KIND_W         = 2;
    localparam int SIDE_W         = 3;
    localparam int POS_W          = 21;
    localparam int NRM_W          = 2;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int VCNT_W         = 6;
    localparam int PC_W           = 4;
    localparam int S_DATA_W       = 24;
    localparam int M_DATA_W       = 72;
    localparam logic [VCNT_W-1:0] VCNT_LAST = 6'd35;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRID_WR = 2'd0,
        KIND_BND_WR  = 2'd1,
        KIND_QUERY   = 2'd2
    } t_kind;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_LEFT   = 3'd0,
        SIDE_RIGHT  = 3'd1,
        SIDE_BOTTOM = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_FRONT  = 3'd4,
        SIDE_BACK   = 3'd5
    } t_side;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_X = 2'd0,
        CFG_CHUNK_Y = 2'd1,
        CFG_CHUNK_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_DISPATCH,
        OP_PROBE,
        OP_DECIDE,
        OP_EMIT
    } t_op;

    // one control word of the microprogram
    typedef struct packed {
        t_op             op;
        t_side           nside;
        logic            ctr_chk;
        logic            nbr_chk;
        logic [PC_W-1:0] tgt;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic query_ok;
        logic center_solid;
        logic covered;
        logic emit_done;
    } t_stat;

    typedef struct packed {
        logic                    cx;
        logic                    cy;
        logic                    cz;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } t_vtx;

    // microprogram step addresses
    localparam logic [PC_W-1:0] ST_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] ST_PROBE_L  = 4'd2;
    localparam logic [PC_W-1:0] ST_PROBE_R  = 4'd3;
    localparam logic [PC_W-1:0] ST_PROBE_B  = 4'd4;
    localparam logic [PC_W-1:0] ST_PROBE_T  = 4'd5;
    localparam logic [PC_W-1:0] ST_PROBE_F  = 4'd6;
    localparam logic [PC_W-1:0] ST_PROBE_K  = 4'd7;
    localparam logic [PC_W-1:0] ST_DECIDE   = 4'd8;
    localparam logic [PC_W-1:0] ST_EMIT     = 4'd9;

    // faces in order front, back, left, right, top, bottom; six vertices each
    function automatic t_vtx cube_vertex(input logic [VCNT_W-1:0] k);
        t_vtx       v;
        logic [2:0] c;
        case (k)
            6'd0:  c = 3'b010;  6'd1:  c = 3'b000;  6'd2:  c = 3'b100;
            6'd3:  c = 3'b010;  6'd4:  c = 3'b100;  6'd5:  c = 3'b110;
            6'd6:  c = 3'b111;  6'd7:  c = 3'b101;  6'd8:  c = 3'b001;
            6'd9:  c = 3'b111;  6'd10: c = 3'b001;  6'd11: c = 3'b011;
            6'd12: c = 3'b011;  6'd13: c = 3'b001;  6'd14: c = 3'b000;
            6'd15: c = 3'b011;  6'd16: c = 3'b000;  6'd17: c = 3'b010;
            6'd18: c = 3'b110;  6'd19: c = 3'b100;  6'd20: c = 3'b101;
            6'd21: c = 3'b110;  6'd22: c = 3'b101;  6'd23: c = 3'b111;
            6'd24: c = 3'b011;  6'd25: c = 3'b010;  6'd26: c = 3'b110;
            6'd27: c = 3'b011;  6'd28: c = 3'b110;  6'd29: c = 3'b111;
            6'd30: c = 3'b000;  6'd31: c = 3'b001;  6'd32: c = 3'b101;
            6'd33: c = 3'b000;  6'd34: c = 3'b101;  6'd35: c = 3'b100;
            default: c = 3'b000;
        endcase
        v.cx = c[2];
        v.cy = c[1];
        v.cz = c[0];
        v.nx = 2'sd0;
        v.ny = 2'sd0;
        v.nz = 2'sd0;
        case (k) inside
            [6'd0:6'd5]:   v.nz = -2'sd1;
            [6'd6:6'd11]:  v.nz = 2'sd1;
            [6'd12:6'd17]: v.nx = -2'sd1;
            [6'd18:6'd23]: v.nx = 2'sd1;
            [6'd24:6'd29]: v.ny = 2'sd1;
            [6'd30:6'd35]: v.ny = -2'sd1;
            default:       v.nx = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/voxel_occlusion_cube_mesher_core.sv =====
// top level of the occlusion-culling cube mesher for one voxel chunk
//
// The block holds one chunk of CHUNK_EDGE^3 block types plus six one-bit boundary planes that
// say which cells of the touching neighbor chunks are solid. An input item (kind in s_tuser)
// writes a grid cell, writes a boundary cell, or queries a cell. A query of a solid block with
// at least one air neighbor returns the 36 vertices of a whole cube, all six faces, each with
// its face normal, m_tlast on the 36th; air or a fully enclosed block returns nothing.
// Control is a ten-step microprogram: fetch, dispatch, six neighbor probes, a decision and
// the emit loop. A write, a spare item or an out-of-range query returns to fetch after
// dispatch, a query of air after the first probe, a culled query after the decision. The
// probe rate is set by the single read port of the grid and plane memories, one neighbor per
// cycle; the emit rate by one vertex per cycle through the output register while m_tready
// allows. The next item is accepted while the last vertex still waits in the output register;
// s_tready stays low during reset. Grid and plane contents are undefined until written; there
// is no clearing pass. Chunk coordinates are to be written on the config port only while
// idle; the block itself does not enforce this.
module voxel_occlusion_cube_mesher_core #(
    parameter int CHUNK_EDGE = vocm_pkg::CHUNK_EDGE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config: index 0 chunk_pos_x, 1 chunk_pos_y, 2 chunk_pos_z
    input  logic                           i_cfg_we,
    input  logic [vocm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vocm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cell_x[3:0] cell_y[7:4] cell_z[11:8] block_kind[19:12] side[22:20] solid[23]
    input  logic [vocm_pkg::S_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [vocm_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pos_x[20:0] pos_y[41:21] pos_z[62:42] normal_x[64:63] normal_y[66:65]
    // normal_z[68:67], zero fill [71:69]
    output logic [vocm_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import vocm_pkg::*;

    // microprogram word drives the datapath, datapath status steers the jumps
    t_uword w_ctl;
    t_stat  w_stat;

    vocm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_word  (w_ctl)
    );

    vocm_dpath #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat)
    );

endmodule

// ===== hdl/vocm_urom.sv =====
// microprogram store: one control word per step
module vocm_urom (
    input  logic [vocm_pkg::PC_W-1:0] i_pc,
    output vocm_pkg::t_uword          o_word
);
    import vocm_pkg::*;

    always_comb begin
        unique case (i_pc)
            ST_FETCH:    o_word = '{op: OP_FETCH,    nside: SIDE_LEFT,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b0, tgt: ST_FETCH};
            ST_DISPATCH: o_word = '{op: OP_DISPATCH, nside: SIDE_LEFT,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b0, tgt: ST_FETCH};
            ST_PROBE_L:  o_word = '{op: OP_PROBE,    nside: SIDE_LEFT,  ctr_chk: 1'b1,
                                    nbr_chk: 1'b0, tgt: ST_FETCH};
            ST_PROBE_R:  o_word = '{op: OP_PROBE,    nside: SIDE_RIGHT, ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_PROBE_B:  o_word = '{op: OP_PROBE,    nside: SIDE_BOTTOM, ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_PROBE_T:  o_word = '{op: OP_PROBE,    nside: SIDE_TOP,   ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_PROBE_F:  o_word = '{op: OP_PROBE,    nside: SIDE_FRONT, ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_PROBE_K:  o_word = '{op: OP_PROBE,    nside: SIDE_BACK,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_DECIDE:   o_word = '{op: OP_DECIDE,   nside: SIDE_LEFT,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b1, tgt: ST_FETCH};
            ST_EMIT:     o_word = '{op: OP_EMIT,     nside: SIDE_LEFT,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b0, tgt: ST_FETCH};
            default:     o_word = '{op: OP_FETCH,    nside: SIDE_LEFT,  ctr_chk: 1'b0,
                                    nbr_chk: 1'b0, tgt: ST_FETCH};
        endcase
    end

endmodule

// ===== hdl/vocm_seq.sv =====
// step counter with conditional jumps over the microprogram
module vocm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vocm_pkg::t_stat   i_stat,
    output vocm_pkg::t_uword  o_word
);
    import vocm_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [PC_W-1:0] pc_inc;

    vocm_urom u_urom (
        .i_pc   (r_pc),
        .o_word (o_word)
    );

    assign pc_inc = r_pc + PC_W'(1);

    always_comb begin
        unique case (o_word.op)
            OP_FETCH:    n_pc = i_stat.in_fire ? pc_inc : r_pc;
            OP_DISPATCH: n_pc = i_stat.query_ok ? pc_inc : o_word.tgt;
            OP_PROBE:    n_pc = (o_word.ctr_chk && !i_stat.center_solid) ? o_word.tgt : pc_inc;
            OP_DECIDE:   n_pc = i_stat.covered ? o_word.tgt : pc_inc;
            OP_EMIT:     n_pc = i_stat.emit_done ? o_word.tgt : r_pc;
            default:     n_pc = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/vocm_dpath.sv =====
// datapath: item latch, grid and boundary memories, neighbor probing, vertex output register
module vocm_dpath #(
    parameter int CHUNK_EDGE = vocm_pkg::CHUNK_EDGE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vocm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vocm_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vocm_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [vocm_pkg::KIND_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vocm_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    input  vocm_pkg::t_uword                   i_ctl,
    output vocm_pkg::t_stat                    o_stat
);
    import vocm_pkg::*;

    localparam int CW     = $clog2(CHUNK_EDGE);
    localparam int GRID_D = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int PLN_D  = 6 * CHUNK_EDGE * CHUNK_EDGE;
    localparam int GA     = $clog2(GRID_D);
    localparam int PA     = $clog2(PLN_D);
    localparam logic [CW-1:0] CMAX = CW'(CHUNK_EDGE - 1);

    function automatic logic [GA-1:0] grid_idx(input logic [CW-1:0] x, y, z);
        return GA'((int'(z) * CHUNK_EDGE + int'(y)) * CHUNK_EDGE + int'(x));
    endfunction

    function automatic logic [PA-1:0] pln_idx(input logic [SIDE_W-1:0] sd,
                                              input logic [CW-1:0] a, b);
        return PA'((int'(sd) * CHUNK_EDGE + int'(a)) * CHUNK_EDGE + int'(b));
    endfunction

    // configuration
    logic signed [CFG_W-1:0] r_cpx, r_cpy, r_cpz;

    // latched item
    logic [KIND_W-1:0] r_kind;
    logic [CRD_W-1:0]  r_x, r_y, r_z;
    logic [BLK_W-1:0]  r_bk;
    logic [SIDE_W-1:0] r_side;
    logic              r_solid;

    // memories
    logic [BLK_W-1:0] mem_grid [GRID_D];
    logic             mem_pln  [PLN_D];
    logic [BLK_W-1:0] r_grid_q;
    logic             r_pln_q;
    logic             r_src_pln;
    logic             r_cov;

    // output register
    logic                    r_ovalid;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;
    logic                    r_last;
    logic [VCNT_W-1:0]       r_vcnt;
    logic signed [POS_W-1:0] r_bx, r_by, r_bz;

    logic [CW-1:0]     cx, cy, cz;
    logic              in_fire;
    logic              in_range;
    logic              query_ok;
    logic [CRD_W-1:0]  ba, bb;
    logic              bnd_side_ok;
    logic              bnd_ok;
    logic              grid_we, pln_we;
    logic              grid_re, pln_re;
    logic [GA-1:0]     grid_wa, grid_ra, nb_ga;
    logic [PA-1:0]     pln_wa, nb_pa;
    logic              nb_pln;
    logic              nbr_solid;
    logic              load;
    logic              emit_load;
    t_vtx              vtx;

    assign s_tready = (i_ctl.op == OP_FETCH) && i_rst_n;
    assign in_fire  = s_tvalid && s_tready;

    assign cx = CW'(r_x);
    assign cy = CW'(r_y);
    assign cz = CW'(r_z);

    assign in_range = (int'(r_x) < CHUNK_EDGE) && (int'(r_y) < CHUNK_EDGE)
                   && (int'(r_z) < CHUNK_EDGE);
    assign query_ok = (r_kind == KIND_QUERY) && in_range;

    // plane coordinates of a boundary write
    always_comb begin
        unique case (r_side) inside
            SIDE_LEFT, SIDE_RIGHT: begin
                ba = r_z; bb = r_y; bnd_side_ok = 1'b1;
            end
            SIDE_BOTTOM, SIDE_TOP: begin
                ba = r_z; bb = r_x; bnd_side_ok = 1'b1;
            end
            SIDE_FRONT, SIDE_BACK: begin
                ba = r_y; bb = r_x; bnd_side_ok = 1'b1;
            end
            default: begin
                ba = r_y; bb = r_x; bnd_side_ok = 1'b0;
            end
        endcase
    end

    assign bnd_ok = bnd_side_ok && (int'(ba) < CHUNK_EDGE) && (int'(bb) < CHUNK_EDGE);

    // neighbor address: grid inside the chunk, boundary plane at the edge
    always_comb begin
        nb_pln = 1'b0;
        nb_ga  = grid_idx(cx, cy, cz);
        nb_pa  = pln_idx(i_ctl.nside, cz, cy);
        unique case (i_ctl.nside)
            SIDE_LEFT: begin
                if (cx != '0) nb_ga = grid_idx(cx - CW'(1), cy, cz);
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_LEFT, cz, cy); end
            end
            SIDE_RIGHT: begin
                if (cx != CMAX) nb_ga = grid_idx(cx + CW'(1), cy, cz);
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_RIGHT, cz, cy); end
            end
            SIDE_BOTTOM: begin
                if (cy != '0) nb_ga = grid_idx(cx, cy - CW'(1), cz);
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_BOTTOM, cz, cx); end
            end
            SIDE_TOP: begin
                if (cy != CMAX) nb_ga = grid_idx(cx, cy + CW'(1), cz);
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_TOP, cz, cx); end
            end
            SIDE_FRONT: begin
                if (cz != '0) nb_ga = grid_idx(cx, cy, cz - CW'(1));
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_FRONT, cy, cx); end
            end
            SIDE_BACK: begin
                if (cz != CMAX) nb_ga = grid_idx(cx, cy, cz + CW'(1));
                else begin nb_pln = 1'b1; nb_pa = pln_idx(SIDE_BACK, cy, cx); end
            end
            default: nb_pln = 1'b0;
        endcase
    end

    assign grid_we = (i_ctl.op == OP_DISPATCH) && (r_kind == KIND_GRID_WR) && in_range;
    assign pln_we  = (i_ctl.op == OP_DISPATCH) && (r_kind == KIND_BND_WR) && bnd_ok;
    assign grid_wa = grid_idx(cx, cy, cz);
    assign pln_wa  = pln_idx(r_side, CW'(ba), CW'(bb));
    assign grid_re = ((i_ctl.op == OP_DISPATCH) && query_ok)
                  || ((i_ctl.op == OP_PROBE) && !nb_pln);
    assign grid_ra = (i_ctl.op == OP_DISPATCH) ? grid_idx(cx, cy, cz) : nb_ga;
    assign pln_re  = (i_ctl.op == OP_PROBE) && nb_pln;

    always_ff @(posedge i_clk) begin
        if (grid_we) mem_grid[grid_wa] <= r_bk;
        if (grid_re) r_grid_q <= mem_grid[grid_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pln_we) mem_pln[pln_wa] <= r_solid;
        if (pln_re) r_pln_q <= mem_pln[nb_pa];
    end

    assign nbr_solid = r_src_pln ? r_pln_q : (r_grid_q != '0);

    // item latch, probe bookkeeping and vertex base
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind  <= s_tuser;
            r_x     <= s_tdata[3:0];
            r_y     <= s_tdata[7:4];
            r_z     <= s_tdata[11:8];
            r_bk    <= s_tdata[19:12];
            r_side  <= s_tdata[22:20];
            r_solid <= s_tdata[23];
        end
        if (i_ctl.op == OP_PROBE) begin
            r_src_pln <= nb_pln;
            if (i_ctl.ctr_chk) begin
                r_cov <= 1'b1;
                r_bx  <= POS_W'(32'(r_cpx) * CHUNK_EDGE + int'(cx));
                r_by  <= POS_W'(32'(r_cpy) * CHUNK_EDGE + int'(cy));
                r_bz  <= POS_W'(32'(r_cpz) * CHUNK_EDGE + int'(cz));
            end else if (i_ctl.nbr_chk) begin
                r_cov <= r_cov & nbr_solid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpx <= '0;
            r_cpy <= '0;
            r_cpz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHUNK_X: r_cpx <= i_cfg_wdata;
                CFG_CHUNK_Y: r_cpy <= i_cfg_wdata;
                CFG_CHUNK_Z: r_cpz <= i_cfg_wdata;
                default:     r_cpx <= r_cpx;
            endcase
        end
    end

    // vertex emission into the output register
    assign vtx       = cube_vertex(r_vcnt);
    assign load      = !r_ovalid || m_tready;
    assign emit_load = (i_ctl.op == OP_EMIT) && load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_vcnt   <= '0;
        end else begin
            if (i_ctl.op == OP_DISPATCH) begin
                r_vcnt <= '0;
            end else if (emit_load) begin
                r_vcnt <= (r_vcnt == VCNT_LAST) ? '0 : r_vcnt + VCNT_W'(1);
            end
            if (emit_load) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_px   <= r_bx + POS_W'(vtx.cx);
            r_py   <= r_by + POS_W'(vtx.cy);
            r_pz   <= r_bz + POS_W'(vtx.cz);
            r_nx   <= vtx.nx;
            r_ny   <= vtx.ny;
            r_nz   <= vtx.nz;
            r_last <= (r_vcnt == VCNT_LAST);
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tlast  = r_last;
    assign m_tdata  = {3'b000, r_nz, r_ny, r_nx, r_pz, r_py, r_px};

    assign o_stat.in_fire      = in_fire;
    assign o_stat.query_ok     = query_ok;
    assign o_stat.center_solid = (r_grid_q != '0);
    assign o_stat.covered      = r_cov & nbr_solid;
    assign o_stat.emit_done    = emit_load && (r_vcnt == VCNT_LAST);

endmodule

// ===== hdl/vocm_chk.sv =====
// port-level checker for the cube mesher and its bind
module vocm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    // a stalled vertex holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled vertex changed");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("vertex valid after reset");

    // every vertex has a unit axis normal and zero fill
    a_nrm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ($countones({m_tdata[64:63] != 2'b00, m_tdata[66:65] != 2'b00,
                                  m_tdata[68:67] != 2'b00}) == 1)
                  && (m_tdata[64:63] != 2'b10) && (m_tdata[66:65] != 2'b10)
                  && (m_tdata[68:67] != 2'b10) && (m_tdata[71:69] == 3'b000))
        else $error("bad normal or fill");

    // an accepted item is dispatched before another is taken
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

endmodule

bind voxel_occlusion_cube_mesher_core vocm_chk u_vocm_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
